@@ rtl/ahdsr_pkg.sv @@
// Shared types, codes and defaults of the AHDSR envelope generator.
package ahdsr_pkg;

	localparam int TIME_BITS_DEF       = 24;
	localparam int LEVEL_FRAC_BITS_DEF = 16;

	localparam int ATTACK_RESET  = 480;
	localparam int HOLD_RESET    = 0;
	localparam int DECAY_RESET   = 9600;
	localparam int SUSTAIN_RESET = 45875;
	localparam int RELEASE_RESET = 14400;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE     = 3'd7;

	localparam logic [1:0] CURVE_LIN = 2'd0;
	localparam logic [1:0] CURVE_SQ  = 2'd1;
	localparam logic [1:0] CURVE_LOG = 2'd2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_GATE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_HOLD    = 3'd2,
		PH_DECAY   = 3'd3,
		PH_SUSTAIN = 3'd4,
		PH_RELEASE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EL_KEEP,
		EL_INC,
		EL_CLR,
		EL_GATE
	} el_op_t;

	typedef enum logic [1:0] {
		LVL_ZERO,
		LVL_ONE,
		LVL_SUST,
		LVL_CALC
	} lvl_sel_t;

	typedef enum logic [1:0] {
		MUL_CURVE,
		MUL_LEVEL,
		MUL_GATE
	} mul_sel_t;

	typedef struct packed {
		phase_t   ph;
		el_op_t   el_op;
		lvl_sel_t lvl_sel;
		logic     lvl_we;
		logic     rsl_load;
		logic     p_one;
		logic     div_start;
		logic     div_step;
		mul_sel_t mul_sel;
		logic     mul_we;
		logic     shape_we;
	} ahdsr_cmd_t;

	typedef struct packed {
		logic e_ge_len;
		logic div_last;
		logic lvl_ge_one;
		logic lvl_le_sust;
		logic lvl_zero;
		logic hold_nz;
	} ahdsr_stat_t;

endpackage

@@ rtl/ahdsr_datapath.sv @@
// Datapath: elapsed counter, level registers, fraction divider and shared multiplier.
module ahdsr_datapath #(
	parameter int TIME_BITS       = ahdsr_pkg::TIME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = ahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [TIME_BITS-1:0]       attack_len,
	input  logic [TIME_BITS-1:0]       hold_len,
	input  logic [TIME_BITS-1:0]       decay_len,
	input  logic [TIME_BITS-1:0]       release_len,
	input  logic [LEVEL_FRAC_BITS:0]   sustain,
	input  logic [1:0]                 curve,
	input  ahdsr_pkg::ahdsr_cmd_t      cmd,
	output ahdsr_pkg::ahdsr_stat_t     stat,
	output logic [LEVEL_FRAC_BITS:0]   cur_level
);

	localparam int LVL_W   = LEVEL_FRAC_BITS + 1;
	localparam int MUL_B_W = (TIME_BITS > LVL_W) ? TIME_BITS : LVL_W;
	localparam int PROD_W  = LVL_W + MUL_B_W;
	localparam int CNT_W   = $clog2(LEVEL_FRAC_BITS);
	localparam logic [LVL_W-1:0]     ONE      = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(LEVEL_FRAC_BITS - 1);

	logic [TIME_BITS-1:0]       elapsed_q;
	logic [LVL_W-1:0]           level_q;
	logic [LVL_W-1:0]           rsl_q;
	logic [LVL_W-1:0]           p_q;
	logic [LVL_W-1:0]           shape_q;
	logic [PROD_W-1:0]          prod_q;
	logic [TIME_BITS-1:0]       rem_q;
	logic [LEVEL_FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;

	logic [TIME_BITS-1:0]       sel_len;
	logic [LVL_W-1:0]           s_eff;
	logic [LVL_W-1:0]           mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	logic [PROD_W-1:0]          prod_d;
	logic [LVL_W-1:0]           prod_lvl;
	logic [LVL_W-1:0]           shape_d;
	logic [LVL_W-1:0]           calc_lvl;
	logic [LVL_W-1:0]           level_d;
	logic [TIME_BITS:0]         rem_dbl;
	logic                       rem_ge;
	logic [TIME_BITS-1:0]       rem_next;
	logic [LEVEL_FRAC_BITS-1:0] quo_next;

	assign s_eff    = (sustain > ONE) ? ONE : sustain;
	assign prod_lvl = prod_q[LEVEL_FRAC_BITS +: LVL_W];

	always_comb begin
		case (cmd.ph)
			ahdsr_pkg::PH_HOLD:    sel_len = hold_len;
			ahdsr_pkg::PH_DECAY:   sel_len = decay_len;
			ahdsr_pkg::PH_RELEASE: sel_len = release_len;
			default:               sel_len = attack_len;
		endcase
	end

	// one quotient bit per step: remainder stays below the length
	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_ge   = rem_dbl >= {1'b0, sel_len};
	assign rem_next = rem_ge ? TIME_BITS'(rem_dbl - {1'b0, sel_len}) : rem_dbl[TIME_BITS-1:0];
	assign quo_next = {quo_q[LEVEL_FRAC_BITS-2:0], rem_ge};

	always_comb begin
		mul_a = p_q;
		mul_b = MUL_B_W'(p_q);
		case (cmd.mul_sel)
			ahdsr_pkg::MUL_CURVE: begin
				mul_a = (curve == ahdsr_pkg::CURVE_LOG) ? ONE - p_q : p_q;
				mul_b = MUL_B_W'(mul_a);
			end
			ahdsr_pkg::MUL_LEVEL: begin
				case (cmd.ph)
					ahdsr_pkg::PH_DECAY: begin
						mul_a = ONE - s_eff;
						mul_b = MUL_B_W'(shape_q);
					end
					ahdsr_pkg::PH_RELEASE: begin
						mul_a = rsl_q;
						mul_b = MUL_B_W'(ONE - shape_q);
					end
					default: begin
						mul_a = shape_q;
						mul_b = MUL_B_W'(ONE);
					end
				endcase
			end
			ahdsr_pkg::MUL_GATE: begin
				mul_a = level_q;
				mul_b = MUL_B_W'(attack_len);
			end
			default: begin
				mul_a = p_q;
				mul_b = MUL_B_W'(p_q);
			end
		endcase
	end

	assign prod_d = {{MUL_B_W{1'b0}}, mul_a} * {{LVL_W{1'b0}}, mul_b};

	always_comb begin
		case (curve)
			ahdsr_pkg::CURVE_LIN: shape_d = p_q;
			ahdsr_pkg::CURVE_SQ:  shape_d = prod_lvl;
			default:              shape_d = ONE - prod_lvl;
		endcase
	end

	always_comb begin
		case (cmd.ph)
			ahdsr_pkg::PH_DECAY:   calc_lvl = ONE - prod_lvl;
			ahdsr_pkg::PH_RELEASE: calc_lvl = prod_lvl;
			default:               calc_lvl = shape_q;
		endcase
	end

	always_comb begin
		case (cmd.lvl_sel)
			ahdsr_pkg::LVL_ZERO: level_d = '0;
			ahdsr_pkg::LVL_ONE:  level_d = ONE;
			ahdsr_pkg::LVL_SUST: level_d = s_eff;
			default:             level_d = calc_lvl;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			level_q   <= '0;
			rsl_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (cmd.el_op)
				ahdsr_pkg::EL_INC:  if (elapsed_q != TIME_MAX) elapsed_q <= elapsed_q + 1'b1;
				ahdsr_pkg::EL_CLR:  elapsed_q <= '0;
				// level never exceeds one, so this stays within the attack length
				ahdsr_pkg::EL_GATE: elapsed_q <= prod_q[LEVEL_FRAC_BITS +: TIME_BITS];
				default:            elapsed_q <= elapsed_q;
			endcase
			if (cmd.lvl_we) level_q <= level_d;
			if (cmd.rsl_load) rsl_q <= level_q;
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= elapsed_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (cmd.p_one) begin
			p_q <= ONE;
		end else if (cmd.div_step && (cnt_q == CNT_LAST)) begin
			p_q <= LVL_W'(quo_next);
		end
		if (cmd.mul_we) prod_q <= prod_d;
		if (cmd.shape_we) shape_q <= shape_d;
	end

	assign stat.e_ge_len    = elapsed_q >= sel_len;
	assign stat.div_last    = cnt_q == CNT_LAST;
	assign stat.lvl_ge_one  = calc_lvl >= ONE;
	assign stat.lvl_le_sust = calc_lvl <= s_eff;
	assign stat.lvl_zero    = calc_lvl == '0;
	assign stat.hold_nz     = hold_len != '0;

	assign cur_level = level_q;

endmodule

@@ rtl/ahdsr_ctrl.sv @@
// Controller: envelope phase and the step sequencer that drives the datapath.
module ahdsr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic                   gate_open,
	input  logic                   loop_en,
	input  logic                   retrig_en,
	input  logic                   out_busy,
	output logic                   out_load,
	output ahdsr_pkg::phase_t      env_phase,
	input  ahdsr_pkg::ahdsr_stat_t stat,
	output ahdsr_pkg::ahdsr_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_START,
		ST_DIV,
		ST_MUL1,
		ST_SHAPE,
		ST_MUL2,
		ST_FIN,
		ST_GATE,
		ST_GMUL,
		ST_OUT
	} state_t;

	state_t            state_q, state_d;
	ahdsr_pkg::phase_t phase_q, phase_d;
	logic              gate_q;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cmd         = '0;
		cmd.ph      = phase_q;
		cmd.el_op   = ahdsr_pkg::EL_KEEP;
		cmd.lvl_sel = ahdsr_pkg::LVL_CALC;
		cmd.mul_sel = ahdsr_pkg::MUL_CURVE;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (opcode == ahdsr_pkg::OP_TICK) ? ST_TICK : ST_GATE;
			end
			ST_TICK: begin
				case (phase_q)
					ahdsr_pkg::PH_IDLE: begin
						cmd.lvl_sel = ahdsr_pkg::LVL_ZERO;
						cmd.lvl_we  = 1'b1;
						state_d     = ST_OUT;
					end
					ahdsr_pkg::PH_SUSTAIN: begin
						cmd.lvl_sel = ahdsr_pkg::LVL_SUST;
						cmd.lvl_we  = 1'b1;
						state_d     = ST_OUT;
					end
					default: begin
						cmd.el_op = ahdsr_pkg::EL_INC;
						state_d   = ST_START;
					end
				endcase
			end
			ST_START: begin
				if (phase_q == ahdsr_pkg::PH_HOLD) begin
					cmd.lvl_sel = ahdsr_pkg::LVL_ONE;
					cmd.lvl_we  = 1'b1;
					if (stat.e_ge_len) begin
						phase_d   = ahdsr_pkg::PH_DECAY;
						cmd.el_op = ahdsr_pkg::EL_CLR;
					end
					state_d = ST_OUT;
				end else if (stat.e_ge_len) begin
					// zero length or past the end: progress is full scale
					cmd.p_one = 1'b1;
					state_d   = ST_MUL1;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_sel = ahdsr_pkg::MUL_CURVE;
				cmd.mul_we  = 1'b1;
				state_d     = ST_SHAPE;
			end
			ST_SHAPE: begin
				cmd.shape_we = 1'b1;
				state_d      = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_sel = ahdsr_pkg::MUL_LEVEL;
				cmd.mul_we  = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.lvl_we = 1'b1;
				case (phase_q)
					ahdsr_pkg::PH_ATTACK: begin
						if (stat.e_ge_len || stat.lvl_ge_one) begin
							cmd.lvl_sel = ahdsr_pkg::LVL_ONE;
							cmd.el_op   = ahdsr_pkg::EL_CLR;
							phase_d     = stat.hold_nz ? ahdsr_pkg::PH_HOLD : ahdsr_pkg::PH_DECAY;
						end
					end
					ahdsr_pkg::PH_DECAY: begin
						if (stat.lvl_le_sust) begin
							cmd.lvl_sel = ahdsr_pkg::LVL_SUST;
							cmd.el_op   = ahdsr_pkg::EL_CLR;
							phase_d     = ahdsr_pkg::PH_SUSTAIN;
						end
					end
					ahdsr_pkg::PH_RELEASE: begin
						if (stat.lvl_zero) begin
							cmd.el_op = ahdsr_pkg::EL_CLR;
							phase_d   = loop_en ? ahdsr_pkg::PH_ATTACK : ahdsr_pkg::PH_IDLE;
						end
					end
					default: ;
				endcase
				state_d = ST_OUT;
			end
			ST_GATE: begin
				state_d = ST_OUT;
				if (gate_q) begin
					if (retrig_en) begin
						phase_d     = ahdsr_pkg::PH_ATTACK;
						cmd.el_op   = ahdsr_pkg::EL_CLR;
						cmd.lvl_sel = ahdsr_pkg::LVL_ZERO;
						cmd.lvl_we  = 1'b1;
					end else begin
						case (phase_q)
							ahdsr_pkg::PH_IDLE: begin
								phase_d   = ahdsr_pkg::PH_ATTACK;
								cmd.el_op = ahdsr_pkg::EL_CLR;
							end
							ahdsr_pkg::PH_DECAY, ahdsr_pkg::PH_SUSTAIN, ahdsr_pkg::PH_RELEASE: begin
								// resume attack at the tick that matches the present level
								cmd.mul_sel = ahdsr_pkg::MUL_GATE;
								cmd.mul_we  = 1'b1;
								state_d     = ST_GMUL;
							end
							default: ;
						endcase
					end
				end else begin
					case (phase_q)
						ahdsr_pkg::PH_ATTACK, ahdsr_pkg::PH_HOLD,
						ahdsr_pkg::PH_DECAY, ahdsr_pkg::PH_SUSTAIN: begin
							cmd.rsl_load = 1'b1;
							cmd.el_op    = ahdsr_pkg::EL_CLR;
							phase_d      = ahdsr_pkg::PH_RELEASE;
						end
						default: ;
					endcase
				end
			end
			ST_GMUL: begin
				cmd.el_op = ahdsr_pkg::EL_GATE;
				phase_d   = ahdsr_pkg::PH_ATTACK;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= ahdsr_pkg::PH_IDLE;
			gate_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (state_q == ST_IDLE && in_valid) begin
				gate_q <= gate_open;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign env_phase = phase_q;

endmodule

@@ rtl/ahdsr_envelope_generator.sv @@
// Top level: configuration registers, result register and the controller/datapath pair.
// AHDSR envelope generator.
// Input channel (in_valid/in_ready, opcode, gate_open): one beat is either a time
// tick (opcode 0) or a gate edge (opcode 1, gate_open 1 rising, 0 falling).
// Output channel (out_valid/out_ready, level, phase_now): one beat per input beat,
// level in Q1.16 (full scale 65536 at default widths), phase 0 idle .. 5 release.
// One input beat is processed at a time. For a tick in attack, decay or release
// the progress fraction comes from a restoring divider that yields one bit per
// cycle, followed by two passes through the shared multiplier. Once the elapsed
// count has reached the phase length the divider is skipped. Ticks in idle, hold
// or sustain and gate edges use neither, apart from rising gates that resume
// attack from decay, sustain or release, which take one multiplier pass.
// The result sits in an output register; the next input beat is accepted while it
// waits, and the controller holds its finished result until that register frees,
// so a stalled receiver stalls the input after at most one further beat.
// Configuration (cfg_write/cfg_index/cfg_data) must be written between beats only; the block does not enforce this.
// Reset clears the envelope to idle at level zero and loads the default settings.
module ahdsr_envelope_generator #(
	parameter int TIME_BITS       = ahdsr_pkg::TIME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = ahdsr_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int CFG_W           = (TIME_BITS > LEVEL_FRAC_BITS + 1) ?
	                                TIME_BITS : LEVEL_FRAC_BITS + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ahdsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic                            gate_open,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [LEVEL_FRAC_BITS:0]        level,
	output logic [2:0]                      phase_now
);

	localparam int LVL_W = LEVEL_FRAC_BITS + 1;

	logic [TIME_BITS-1:0] attack_q;
	logic [TIME_BITS-1:0] hold_q;
	logic [TIME_BITS-1:0] decay_q;
	logic [LVL_W-1:0]     sustain_q;
	logic [TIME_BITS-1:0] release_q;
	logic                 loop_q;
	logic                 retrig_q;
	logic [1:0]           curve_q;

	logic                   out_valid_q;
	logic [LVL_W-1:0]       level_q;
	logic [2:0]             phase_now_q;
	logic                   out_load;
	logic                   out_busy;
	logic [LVL_W-1:0]       cur_level;
	ahdsr_pkg::phase_t      env_phase;
	ahdsr_pkg::ahdsr_cmd_t  cmd;
	ahdsr_pkg::ahdsr_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= TIME_BITS'(ahdsr_pkg::ATTACK_RESET);
			hold_q    <= TIME_BITS'(ahdsr_pkg::HOLD_RESET);
			decay_q   <= TIME_BITS'(ahdsr_pkg::DECAY_RESET);
			sustain_q <= LVL_W'(ahdsr_pkg::SUSTAIN_RESET);
			release_q <= TIME_BITS'(ahdsr_pkg::RELEASE_RESET);
			loop_q    <= 1'b0;
			retrig_q  <= 1'b0;
			curve_q   <= ahdsr_pkg::CURVE_LIN;
		end else if (cfg_write) begin
			case (cfg_index)
				ahdsr_pkg::REG_ATTACK:    attack_q  <= cfg_data[TIME_BITS-1:0];
				ahdsr_pkg::REG_HOLD:      hold_q    <= cfg_data[TIME_BITS-1:0];
				ahdsr_pkg::REG_DECAY:     decay_q   <= cfg_data[TIME_BITS-1:0];
				ahdsr_pkg::REG_SUSTAIN:   sustain_q <= cfg_data[LVL_W-1:0];
				ahdsr_pkg::REG_RELEASE:   release_q <= cfg_data[TIME_BITS-1:0];
				ahdsr_pkg::REG_LOOP:      loop_q    <= cfg_data[0];
				ahdsr_pkg::REG_RETRIGGER: retrig_q  <= cfg_data[0];
				ahdsr_pkg::REG_CURVE:
					// unused curve code falls back to the log curve
					curve_q <= (cfg_data[1:0] > ahdsr_pkg::CURVE_LOG) ?
						ahdsr_pkg::CURVE_LOG : cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q     <= cur_level;
			phase_now_q <= 3'(env_phase);
		end
	end

	ahdsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.gate_open (gate_open),
		.loop_en   (loop_q),
		.retrig_en (retrig_q),
		.out_busy  (out_busy),
		.out_load  (out_load),
		.env_phase (env_phase),
		.stat      (stat),
		.cmd       (cmd)
	);

	ahdsr_datapath #(
		.TIME_BITS       (TIME_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.attack_len  (attack_q),
		.hold_len    (hold_q),
		.decay_len   (decay_q),
		.release_len (release_q),
		.sustain     (sustain_q),
		.curve       (curve_q),
		.cmd         (cmd),
		.stat        (stat),
		.cur_level   (cur_level)
	);

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase_now = phase_now_q;

endmodule

@@ rtl/ahdsr_checker.sv @@
// Port-level assertions for the AHDSR envelope generator, bound to the top level.
module ahdsr_checker #(
	parameter int LEVEL_FRAC_BITS = ahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [LEVEL_FRAC_BITS:0] level,
	input logic [2:0]               phase_now
);

	localparam logic [LEVEL_FRAC_BITS:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(phase_now))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a beat is in work");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= ONE)
		else $error("level above full scale");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_now == ahdsr_pkg::PH_IDLE |-> level == '0)
		else $error("idle phase with nonzero level");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_now == ahdsr_pkg::PH_HOLD |-> level == ONE)
		else $error("hold phase below full scale");

endmodule

bind ahdsr_envelope_generator ahdsr_checker #(
	.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_ahdsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level     (level),
	.phase_now (phase_now)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the AHDSR envelope generator: directed cases, then random notes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_IDX_W = ahdsr_pkg::CFG_IDX_W;
	localparam int CFG_W = ahdsr_pkg::TIME_BITS_DEF;
	localparam int LVL_W = ahdsr_pkg::LEVEL_FRAC_BITS_DEF + 1;
	localparam int FRAC = ahdsr_pkg::LEVEL_FRAC_BITS_DEF;
	localparam longint unsigned FULL = longint'(1) << ahdsr_pkg::LEVEL_FRAC_BITS_DEF;
	localparam longint unsigned TIME_LIMIT = (longint'(1) << ahdsr_pkg::TIME_BITS_DEF) - 1;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [LVL_W-1:0]  lvl;
		ahdsr_pkg::phase_t ph;
	} env_beat_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 opcode    = ahdsr_pkg::OP_TICK;
	logic                 gate_open = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LVL_W-1:0]     level;
	logic [2:0]           phase_now;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          errors         = 0;

	env_beat_t expected_env[$];

	// envelope state and settings as the block should hold them
	ahdsr_pkg::phase_t env_ph;
	longint unsigned   env_elapsed, env_lvl, env_rsl;
	longint unsigned   atk_len, hold_len, dec_len, sus_lvl, rel_len;
	logic              loop_on, retrig_on;
	logic [1:0]        curve_sel;

	ahdsr_envelope_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.gate_open (gate_open),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.phase_now (phase_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint unsigned sustain_eff();
		return (sus_lvl > FULL) ? FULL : sus_lvl;
	endfunction

	function automatic longint unsigned progress_of(input longint unsigned len);
		longint unsigned p;
		if (len == 0)
			return FULL;
		p = (env_elapsed * FULL) / len;
		return (p > FULL) ? FULL : p;
	endfunction

	function automatic longint unsigned shape(input longint unsigned p);
		case (curve_sel)
			ahdsr_pkg::CURVE_LIN: return p;
			ahdsr_pkg::CURVE_SQ:  return (p * p) >> FRAC;
			default:              return FULL - (((FULL - p) * (FULL - p)) >> FRAC);
		endcase
	endfunction

	function automatic longint unsigned phase_level();
		longint unsigned s;
		s = sustain_eff();
		case (env_ph)
			ahdsr_pkg::PH_ATTACK:  return shape(progress_of(atk_len));
			ahdsr_pkg::PH_HOLD:    return FULL;
			ahdsr_pkg::PH_DECAY:   return FULL - (((FULL - s) * shape(progress_of(dec_len)))
				>> FRAC);
			ahdsr_pkg::PH_SUSTAIN: return s;
			ahdsr_pkg::PH_RELEASE: return (env_rsl * (FULL - shape(progress_of(rel_len))))
				>> FRAC;
			default:               return 0;
		endcase
	endfunction

	function automatic void envelope_tick();
		longint unsigned s;
		s = sustain_eff();
		if (env_ph == ahdsr_pkg::PH_IDLE || env_ph == ahdsr_pkg::PH_SUSTAIN) begin
			env_lvl = phase_level();
			return;
		end
		if (env_elapsed < TIME_LIMIT)
			env_elapsed++;
		env_lvl = phase_level();
		case (env_ph)
			ahdsr_pkg::PH_ATTACK: if (env_elapsed >= atk_len || env_lvl >= FULL) begin
				env_lvl     = FULL;
				env_ph      = (hold_len > 0) ? ahdsr_pkg::PH_HOLD : ahdsr_pkg::PH_DECAY;
				env_elapsed = 0;
			end
			ahdsr_pkg::PH_HOLD: if (env_elapsed >= hold_len) begin
				env_ph      = ahdsr_pkg::PH_DECAY;
				env_elapsed = 0;
			end
			ahdsr_pkg::PH_DECAY: if (env_lvl <= s) begin
				env_lvl     = s;
				env_ph      = ahdsr_pkg::PH_SUSTAIN;
				env_elapsed = 0;
			end
			ahdsr_pkg::PH_RELEASE: if (env_lvl == 0) begin
				env_ph      = loop_on ? ahdsr_pkg::PH_ATTACK : ahdsr_pkg::PH_IDLE;
				env_elapsed = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic void envelope_gate(input logic rising);
		if (rising) begin
			if (retrig_on) begin
				env_ph      = ahdsr_pkg::PH_ATTACK;
				env_elapsed = 0;
				env_lvl     = 0;
			end else if (env_ph == ahdsr_pkg::PH_IDLE) begin
				env_ph      = ahdsr_pkg::PH_ATTACK;
				env_elapsed = 0;
			end else if (env_ph == ahdsr_pkg::PH_DECAY || env_ph == ahdsr_pkg::PH_SUSTAIN ||
			             env_ph == ahdsr_pkg::PH_RELEASE) begin
				// resume attack where its curve would be at the present level
				env_ph      = ahdsr_pkg::PH_ATTACK;
				env_elapsed = (env_lvl * atk_len) >> FRAC;
				if (env_elapsed > TIME_LIMIT)
					env_elapsed = TIME_LIMIT;
			end
		end else if (env_ph == ahdsr_pkg::PH_ATTACK || env_ph == ahdsr_pkg::PH_HOLD ||
		             env_ph == ahdsr_pkg::PH_DECAY || env_ph == ahdsr_pkg::PH_SUSTAIN) begin
			env_rsl     = env_lvl;
			env_ph      = ahdsr_pkg::PH_RELEASE;
			env_elapsed = 0;
		end
	endfunction

	function automatic void predict_envelope(input logic op, input logic g);
		env_beat_t b;
		if (op == ahdsr_pkg::OP_TICK)
			envelope_tick();
		else
			envelope_gate(g);
		b.lvl = env_lvl[LVL_W-1:0];
		b.ph  = env_ph;
		expected_env.push_back(b);
	endfunction

	function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [CFG_W-1:0] d);
		case (idx)
			ahdsr_pkg::REG_ATTACK:    atk_len   = 64'(d);
			ahdsr_pkg::REG_HOLD:      hold_len  = 64'(d);
			ahdsr_pkg::REG_DECAY:     dec_len   = 64'(d);
			ahdsr_pkg::REG_SUSTAIN:   sus_lvl   = 64'(d[LVL_W-1:0]);
			ahdsr_pkg::REG_RELEASE:   rel_len   = 64'(d);
			ahdsr_pkg::REG_LOOP:      loop_on   = d[0];
			ahdsr_pkg::REG_RETRIGGER: retrig_on = d[0];
			ahdsr_pkg::REG_CURVE:     curve_sel = (d[1:0] > ahdsr_pkg::CURVE_LOG) ?
				ahdsr_pkg::CURVE_LOG : d[1:0];
			default: ;
		endcase
	endfunction

	// receiver side: random stalls at the current rate
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		env_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_env.size() == 0) begin
				$error("result beat with nothing expected: level %0d, phase_now %0d",
					level, phase_now);
				errors++;
			end else begin
				want = expected_env.pop_front();
				if (level !== want.lvl) begin
					$error("level: expected %0d, got %0d", want.lvl, level);
					errors++;
				end
				if (phase_now !== want.ph) begin
					$error("phase_now: expected %0d, got %0d", want.ph, phase_now);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(input logic op, input logic g);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		gate_open <= g;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_envelope(op, g);
	endtask

	task automatic send_tick();
		send_beat(ahdsr_pkg::OP_TICK, $urandom_range(0, 1) == 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_env.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] hold,
	                         input logic [CFG_W-1:0] dec, input logic [CFG_W-1:0] sus,
	                         input logic [CFG_W-1:0] rel, input logic [CFG_W-1:0] lp,
	                         input logic [CFG_W-1:0] rt, input logic [CFG_W-1:0] cv);
		logic [CFG_W-1:0] vals [8];
		int i;
		vals[ahdsr_pkg::REG_ATTACK]    = atk;
		vals[ahdsr_pkg::REG_HOLD]      = hold;
		vals[ahdsr_pkg::REG_DECAY]     = dec;
		vals[ahdsr_pkg::REG_SUSTAIN]   = sus;
		vals[ahdsr_pkg::REG_RELEASE]   = rel;
		vals[ahdsr_pkg::REG_LOOP]      = lp;
		vals[ahdsr_pkg::REG_RETRIGGER] = rt;
		vals[ahdsr_pkg::REG_CURVE]     = cv;
		drain();
		for (i = ahdsr_pkg::REG_ATTACK; i <= ahdsr_pkg::REG_CURVE; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= vals[i];
			store_setting(i[CFG_IDX_W-1:0], vals[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_length();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			return '0;
		if (pick < 15)
			return CFG_W'($urandom_range(1, 12));
		if (pick < 18)
			return CFG_W'($urandom_range(13, 200));
		if (pick < 19)
			return '1;
		return CFG_W'($urandom);
	endfunction

	function automatic logic [CFG_W-1:0] rand_sustain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(FULL);
			// above full scale, with junk in the bits beyond the register
			2: return CFG_W'($urandom & 32'h00FE_0000) | CFG_W'($urandom_range(65537, 131071));
			default: return CFG_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// well-formed notes with random lengths, plus some stray beats
	task automatic play_notes(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_beat(($urandom_range(0, 1) == 1) ? ahdsr_pkg::OP_GATE : ahdsr_pkg::OP_TICK,
						$urandom_range(0, 1) == 1);
					sent++;
				end
			end else begin
				send_beat(ahdsr_pkg::OP_GATE, 1'b1);
				sent++;
				repeat ($urandom_range(0, 40)) begin
					if ($urandom_range(0, 19) == 0)
						send_beat(ahdsr_pkg::OP_GATE, 1'b1);
					else
						send_tick();
					sent++;
				end
				send_beat(ahdsr_pkg::OP_GATE, 1'b0);
				sent++;
				repeat ($urandom_range(0, 30)) begin
					send_tick();
					sent++;
				end
			end
		end
	endtask

	task automatic test_defaults();
		send_beat(ahdsr_pkg::OP_TICK, 1'b1);
		send_beat(ahdsr_pkg::OP_GATE, 1'b0);
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_tick();
		send_beat(ahdsr_pkg::OP_GATE, 1'b0);
	endtask

	task automatic test_zero_length_phases();
		// sustain over full scale, loop on, curve code three; upper data bits set
		configure(24'd0, 24'd2, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF);
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		repeat (4) send_tick();
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_beat(ahdsr_pkg::OP_GATE, 1'b0);
		send_tick();
		send_tick();
	endtask

	task automatic test_elapsed_saturation();
		// full-level gate in sustain lands attack at the top of the elapsed counter
		configure(24'hFFFFFF, 24'd0, 24'd0, 24'd65536, 24'd0, 24'd0, 24'd0,
			24'(ahdsr_pkg::CURVE_LOG));
		send_tick();
		send_tick();
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_tick();
	endtask

	task automatic test_retrigger_curves();
		configure(24'd3, 24'd1, 24'd3, 24'd0, 24'd5, 24'd0, 24'd1, 24'(ahdsr_pkg::CURVE_SQ));
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_tick();
		send_tick();
		send_beat(ahdsr_pkg::OP_GATE, 1'b1);
		send_beat(ahdsr_pkg::OP_GATE, 1'b0);
		send_tick();
	endtask

	task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (9) begin
			configure(rand_length(), rand_length(), rand_length(), rand_sustain(),
				rand_length(), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
			play_notes(30);
		end
	endtask

	initial begin
		env_ph      = ahdsr_pkg::PH_IDLE;
		env_elapsed = 0;
		env_lvl     = 0;
		env_rsl     = 0;
		atk_len     = ahdsr_pkg::ATTACK_RESET;
		hold_len    = ahdsr_pkg::HOLD_RESET;
		dec_len     = ahdsr_pkg::DECAY_RESET;
		sus_lvl     = ahdsr_pkg::SUSTAIN_RESET;
		rel_len     = ahdsr_pkg::RELEASE_RESET;
		loop_on     = 1'b0;
		retrig_on   = 1'b0;
		curve_sel   = ahdsr_pkg::CURVE_LIN;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_zero_length_phases();
		test_elapsed_saturation();
		test_retrigger_curves();
		test_random(0, 0);
		test_random(54, 0);
		test_random(0, 54);
		test_random(27, 27);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ ahdsr_envelope_generator.f @@
rtl/ahdsr_pkg.sv
rtl/ahdsr_datapath.sv
rtl/ahdsr_ctrl.sv
rtl/ahdsr_envelope_generator.sv
rtl/ahdsr_checker.sv
tb/sv/tb_top.sv
